// ===== src/u8u16_pkg.sv =====
// Shared types, codes and constants of the UTF-8 to UTF-16 decoder.
// Used by every module of the decoder; depends on nothing else.
package u8u16_pkg;

   localparam int BYTE_W  = 8;
   localparam int UNIT_W  = 16;
   localparam int STAT_W  = 3;
   localparam int CLASS_W = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [STAT_W-1:0] STATUS_UNIT     = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_BADCONT  = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_FOURBYTE = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_INVALID  = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_TRUNC    = 3'd4;
   localparam logic [STAT_W-1:0] STATUS_END      = 3'd5;

   localparam logic [CLASS_W-1:0] CLASS_ASCII    = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_LEAD2    = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_LEAD3    = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_LEAD4    = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_BAD_LEAD = 3'd4;

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              end_of_text;
   } req_type;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic [STAT_W-1:0] status;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic [CLASS_W-1:0] byte_class;
      logic               cont_ok;
      logic [BYTE_W-1:0]  in_byte;
      logic               end_of_text;
   } item_type;

endpackage

// ===== src/u8u16_front.sv =====
// Front stage: accepts input bytes, classifies the lead pattern and registers them.
// Depends on u8u16_pkg.
module u8u16_front import u8u16_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_payload,
   output logic     item_valid,
   input  logic     item_ready,
   output item_type item
);

   logic     stage_valid_ff, stage_valid_in;
   item_type stage_item_ff, stage_item_in;
   logic     take;

   assign req_ready = !stage_valid_ff || item_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      logic [BYTE_W-1:0] b;
      b = req_payload.in_byte;
      stage_item_in.in_byte     = b;
      stage_item_in.end_of_text = req_payload.end_of_text;
      stage_item_in.cont_ok     = (b[7:6] == 2'b10);
      priority if (b[7] == 1'b0) begin
         stage_item_in.byte_class = CLASS_ASCII;
      end else if (b[7:5] == 3'b110) begin
         stage_item_in.byte_class = CLASS_LEAD2;
      end else if (b[7:4] == 4'b1110) begin
         stage_item_in.byte_class = CLASS_LEAD3;
      end else if (b[7:3] == 5'b11110) begin
         stage_item_in.byte_class = CLASS_LEAD4;
      end else begin
         stage_item_in.byte_class = CLASS_BAD_LEAD;
      end
   end

   assign stage_valid_in = take || (stage_valid_ff && !item_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (take) begin
         stage_item_ff <= stage_item_in;
      end
   end

   assign item_valid = stage_valid_ff;
   assign item       = stage_item_ff;

endmodule

// ===== src/u8u16_queue.sv =====
// Short queue of classified bytes between the front and back stages.
// Depends on u8u16_pkg.
module u8u16_queue import u8u16_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== src/u8u16_back.sv =====
// Back stage: sequence state, code unit assembly and the registered result beat.
// Depends on u8u16_pkg.
module u8u16_back import u8u16_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   output logic     item_ready,
   input  item_type item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_payload
);

   logic [1:0]        pending_ff, pending_in;
   logic [UNIT_W-1:0] partial_ff, partial_in;
   logic              bad_ff, bad_in;
   logic              halted_ff, halted_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic              emit;
   logic              step;

   assign item_ready = !out_valid_ff || rsp_ready;
   assign step       = item_valid && item_ready;

   always_comb begin
      logic              eot;
      logic              bad_next;
      logic [UNIT_W-1:0] unit;
      eot        = item.end_of_text;
      bad_next   = bad_ff || !item.cont_ok;
      unit       = partial_ff | {{(UNIT_W-6){1'b0}}, item.in_byte[5:0]};
      pending_in = pending_ff;
      partial_in = partial_ff;
      bad_in     = bad_ff;
      halted_in  = halted_ff;
      emit       = 1'b0;
      out_in.code_unit   = '0;
      out_in.status      = STATUS_UNIT;
      out_in.last_result = eot;
      if (halted_ff) begin
         emit          = eot;
         out_in.status = STATUS_END;
      end else if (pending_ff == PEND_NONE) begin
         unique case (item.byte_class)
            CLASS_ASCII: begin
               emit             = 1'b1;
               out_in.code_unit = {{(UNIT_W-7){1'b0}}, item.in_byte[6:0]};
            end
            CLASS_LEAD2: begin
               partial_in    = {5'b0, item.in_byte[4:0], 6'b0};
               pending_in    = PEND_ONE;
               bad_in        = 1'b0;
               emit          = eot;
               out_in.status = STATUS_TRUNC;
            end
            CLASS_LEAD3: begin
               partial_in    = {item.in_byte[3:0], 12'b0};
               pending_in    = PEND_TWO;
               bad_in        = 1'b0;
               emit          = eot;
               out_in.status = STATUS_TRUNC;
            end
            CLASS_LEAD4: begin
               halted_in     = 1'b1;
               emit          = 1'b1;
               out_in.status = STATUS_FOURBYTE;
            end
            default: begin
               halted_in     = 1'b1;
               emit          = 1'b1;
               out_in.status = STATUS_INVALID;
            end
         endcase
      end else if (pending_ff != PEND_ONE) begin
         bad_in        = bad_next;
         partial_in    = partial_ff | {4'b0, item.in_byte[5:0], 6'b0};
         pending_in    = PEND_ONE;
         emit          = eot;
         out_in.status = STATUS_TRUNC;
      end else begin
         pending_in = PEND_NONE;
         partial_in = '0;
         bad_in     = 1'b0;
         emit       = 1'b1;
         if (bad_next) begin
            out_in.status = STATUS_BADCONT;
         end else begin
            out_in.code_unit = unit;
         end
      end
      if (emit && eot) begin
         pending_in = PEND_NONE;
         partial_in = '0;
         bad_in     = 1'b0;
         halted_in  = 1'b0;
      end
   end

   assign out_valid_in = (step && emit) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= PEND_NONE;
         partial_ff   <= '0;
         bad_ff       <= 1'b0;
         halted_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (step) begin
            pending_ff <= pending_in;
            partial_ff <= partial_in;
            bad_ff     <= bad_in;
            halted_ff  <= halted_in;
         end
      end
      if (step && emit) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ===== src/utf8_to_utf16_decoder_top.sv =====
// Top level of the UTF-8 to UTF-16 decoder: front stage, queue and back stage.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
//
//   Channel  Direction  Handshake            Beat
//   req      in         req_valid/req_ready  one UTF-8 byte with end-of-text mark
//   rsp      out        rsp_valid/rsp_ready  one code unit or status with last mark
//
// One byte is taken per cycle while req_ready is high; the back stage registers the sequence state per byte.
// A closing byte passes the front stage register and the queue before the back stage registers its result.
// Synchronous reset clears control state and valid flags, not data; no clearing pass is needed.
// A stalled result holds in the output register while the queue keeps filling.
module utf8_to_utf16_decoder_top import u8u16_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic     front_valid, front_ready;
   item_type front_item;
   logic     back_valid, back_ready;
   item_type back_item;

   u8u16_front front_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .item_valid  (front_valid),
      .item_ready  (front_ready),
      .item        (front_item)
   );

   u8u16_queue queue_i (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_item  (back_item)
   );

   u8u16_back back_i (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (back_valid),
      .item_ready  (back_ready),
      .item        (back_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== src/u8u16_checker.sv =====
// Port-level checks of the decoder, attached to the top level by a bind.
// Depends on u8u16_pkg and utf8_to_utf16_decoder_top.
module u8u16_checker import u8u16_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result beat changed or dropped.");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_UNIT |-> rsp_payload.code_unit == '0)
      else $error("Error beat carries a nonzero code unit.");

   a_close_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_END || rsp_payload.status == STATUS_TRUNC)
      |-> rsp_payload.last_result)
      else $error("End or truncation beat does not close the string.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= STATUS_END)
      else $error("Result beat carries an undefined status.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result beat shown right after reset.");

endmodule

bind utf8_to_utf16_decoder_top u8u16_checker checker_i (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
